// ----- rtl/core/acc_pkg.sv -----
// Shared types, register indexes and mask helpers for the APIC ID core counter.
package acc_pkg;

    typedef logic [1:0] t_cfg_idx;

    localparam t_cfg_idx CFG_LP_PER_CORE       = 2'd0;
    localparam t_cfg_idx CFG_CORES_PER_PACKAGE = 2'd1;
    localparam t_cfg_idx CFG_LP_PER_PACKAGE    = 2'd2;

    typedef struct packed {
        logic [7:0] lp_per_core;
        logic [6:0] cores_per_package;
        logic [7:0] lp_per_package;
    } t_cfg;

    typedef enum logic [1:0] {
        S_IDLE   = 2'b01,
        S_SEARCH = 2'b10
    } t_state;

    // bit length of (n - 1) within 8 bits
    function automatic logic [3:0] topo_field_bits(input logic [7:0] n);
        logic [7:0] v;
        logic [3:0] w;
        v = n - 8'd1;
        w = 4'd0;
        for (int b = 0; b < 8; b++) begin
            if (v[b]) begin
                w = 4'(b + 1);
            end
        end
        return w;
    endfunction

endpackage

// ----- rtl/core/acc_key_gen.sv -----
// Core key builder: topology masks from the configuration applied to one APIC ID.
module acc_key_gen (
    input  acc_pkg::t_cfg i_cfg,
    input  logic [7:0]    i_apic_id,
    output logic [7:0]    o_key
);

    logic [3:0]  core_shift;
    logic [3:0]  core_width;
    logic [3:0]  pkg_shift;
    logic [4:0]  top_shift;
    logic [15:0] lo_mask;
    logic [15:0] hi_mask;
    logic [7:0]  core_mask;
    logic [7:0]  pkg_mask;

    always_comb begin
        core_shift = acc_pkg::topo_field_bits(i_cfg.lp_per_core);
        core_width = acc_pkg::topo_field_bits({1'b0, i_cfg.cores_per_package});
        pkg_shift  = acc_pkg::topo_field_bits(i_cfg.lp_per_package);
        top_shift  = 5'(core_shift) + 5'(core_width);
        lo_mask    = 16'h00ff << core_shift;
        hi_mask    = 16'h00ff << top_shift;
        core_mask  = lo_mask[7:0] ^ hi_mask[7:0];
        pkg_mask   = 8'hff << pkg_shift;
        o_key      = i_apic_id & (pkg_mask | core_mask);
    end

endmodule

// ----- rtl/core/apic_id_core_counter_unit.sv -----
// APIC ID core counter: top level with key memory walk and result register.
// An accepted beat is served by a walk of the stored core keys through the single read
// port of the key memory, one key per cycle, each read registered before its compare.
// The walk covers the n keys held (fewer on an early match), up to MAX_PROCESSORS. The
// next beat is taken while the previous result still waits in the output register.
module apic_id_core_counter_unit #(
    parameter int MAX_PROCESSORS = 256
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [7:0] i_apic_id,
    input  logic       i_start_list,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [8:0] o_core_count,
    output logic [7:0] o_bucket_index,
    output logic       o_new_core,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [1:0] i_cfg_index,
    input  logic [7:0] i_cfg_data
);

    localparam int AW = (MAX_PROCESSORS > 1) ? $clog2(MAX_PROCESSORS) : 1;
    localparam int CW = $clog2(MAX_PROCESSORS + 1);
    localparam logic [CW-1:0] LIMIT = CW'(MAX_PROCESSORS);
    localparam logic [AW-1:0] LAST  = AW'(MAX_PROCESSORS - 1);

    acc_pkg::t_state r_state;
    acc_pkg::t_cfg   r_cfg;
    logic [7:0]      key_in;
    logic [7:0]      r_key;
    logic [CW-1:0]   r_count;
    logic [CW-1:0]   r_rd_idx;
    logic [AW-1:0]   r_cmp_idx;
    logic            r_cmp_vld;
    logic [7:0]      r_rdata;
    logic [7:0]      r_mem [MAX_PROCESSORS];
    logic            r_out_vld;
    logic [8:0]      r_out_count;
    logic [7:0]      r_out_index;
    logic            r_out_new;

    logic            in_acc;
    logic            more;
    logic            hit;
    logic            done;
    logic            advance;
    logic            fin;
    logic            room;
    logic            store;
    logic [CW-1:0]   n_count;
    logic [AW-1:0]   n_idx;

    acc_key_gen u_key_gen (
        .i_cfg     (r_cfg),
        .i_apic_id (i_apic_id),
        .o_key     (key_in)
    );

    assign o_cfg_ready    = 1'b1;
    assign o_in_stall     = (r_state != acc_pkg::S_IDLE);
    assign o_out_valid    = r_out_vld;
    assign o_core_count   = r_out_count;
    assign o_bucket_index = r_out_index;
    assign o_new_core     = r_out_new;

    always_comb begin
        in_acc  = i_in_valid && !o_in_stall;
        more    = (r_rd_idx < r_count);
        hit     = r_cmp_vld && (r_rdata == r_key);
        done    = (r_state == acc_pkg::S_SEARCH) && (hit || (!more && !r_cmp_vld));
        advance = (r_state == acc_pkg::S_SEARCH) && !done;
        fin     = done && (!r_out_vld || !i_out_stall);
        room    = (r_count < LIMIT);
        store   = fin && !hit && room;
        n_count = store ? CW'(r_count + 1'b1) : r_count;
        if (hit) begin
            n_idx = r_cmp_idx;
        end else if (room) begin
            n_idx = r_count[AW-1:0];
        end else begin
            n_idx = LAST;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.lp_per_core       <= 8'd1;
            r_cfg.cores_per_package <= 7'd1;
            r_cfg.lp_per_package    <= 8'd1;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                acc_pkg::CFG_LP_PER_CORE:       r_cfg.lp_per_core       <= i_cfg_data;
                acc_pkg::CFG_CORES_PER_PACKAGE: r_cfg.cores_per_package <= i_cfg_data[6:0];
                acc_pkg::CFG_LP_PER_PACKAGE:    r_cfg.lp_per_package    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= acc_pkg::S_IDLE;
            r_count   <= '0;
            r_rd_idx  <= '0;
            r_cmp_vld <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            unique case (r_state)
                acc_pkg::S_IDLE: begin
                    if (in_acc) begin
                        r_state   <= acc_pkg::S_SEARCH;
                        r_rd_idx  <= '0;
                        r_cmp_vld <= 1'b0;
                        if (i_start_list) begin
                            r_count <= '0;
                        end
                    end
                end
                acc_pkg::S_SEARCH: begin
                    if (advance) begin
                        r_cmp_vld <= more;
                        if (more) begin
                            r_rd_idx <= CW'(r_rd_idx + 1'b1);
                        end
                    end
                    if (fin) begin
                        r_state <= acc_pkg::S_IDLE;
                        r_count <= n_count;
                    end
                end
                default: r_state <= acc_pkg::S_IDLE;
            endcase
            if (fin) begin
                r_out_vld <= 1'b1;
            end else if (r_out_vld && !i_out_stall) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_key <= key_in;
        end
        if (advance && more) begin
            r_rdata   <= r_mem[r_rd_idx[AW-1:0]];
            r_cmp_idx <= r_rd_idx[AW-1:0];
        end
        if (store) begin
            r_mem[r_count[AW-1:0]] <= r_key;
        end
        if (fin) begin
            r_out_count <= 9'(n_count);
            r_out_index <= 8'(n_idx);
            r_out_new   <= store;
        end
    end

endmodule

// ----- rtl/core/acc_checker.sv -----
// Port-level checks for the APIC ID core counter, bound to the top level.
module acc_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       o_in_stall,
    input logic       o_out_valid,
    input logic       i_out_stall,
    input logic [8:0] o_core_count,
    input logic [7:0] o_bucket_index,
    input logic       o_new_core
);

    a_busy_after_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input taken again in the cycle after a beat");

    a_count_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_core_count != 9'd0)
        else $error("result with zero core count");

    a_index_below_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ({1'b0, o_bucket_index} < o_core_count))
        else $error("bucket index not below core count");

    a_new_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_new_core |-> ({1'b0, o_bucket_index} + 9'd1 == o_core_count))
        else $error("new core not placed in the last bucket");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_core_count)
            && $stable(o_bucket_index) && $stable(o_new_core))
        else $error("stalled result changed");

endmodule

bind apic_id_core_counter_unit acc_checker u_acc_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in_valid),
    .o_in_stall     (o_in_stall),
    .o_out_valid    (o_out_valid),
    .i_out_stall    (i_out_stall),
    .o_core_count   (o_core_count),
    .o_bucket_index (o_bucket_index),
    .o_new_core     (o_new_core)
);
